>>> design/name_hash_table_lookup_top_assert.svh
// assertion macros for the name hash lookup block
// no dependencies; included by modules that carry concurrent checks
`ifndef NAME_HASH_TABLE_LOOKUP_TOP_ASSERT_SVH
`define NAME_HASH_TABLE_LOOKUP_TOP_ASSERT_SVH

// same-cycle implication, checks off while reset is high
`define NHT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checks off while reset is high
`define NHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/nht_pkg.sv
// shared constants and types for the name hash lookup block
// no dependencies; used by nht_search and name_hash_table_lookup_top
package nht_pkg;

   localparam int unsigned TABLE_DEPTH_DEF = 4096;

   localparam int unsigned HASH_W        = 32;
   localparam int unsigned ENTRY_INDEX_W = 12;
   localparam int unsigned COUNT_W       = 13;
   localparam int unsigned BYTE_W        = 8;

   localparam logic [HASH_W-1:0] HASH_BASIS = 32'h811c9dc5;
   localparam logic [HASH_W-1:0] HASH_MULT  = 32'h00199933;

   // request opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_NAME  = 1'b1;

   typedef struct packed {
      logic                     en;
      logic [ENTRY_INDEX_W-1:0] entry_index;
      logic [HASH_W-1:0]        entry_hash;
   } nht_wr_type;

   typedef struct packed {
      logic              start;
      logic [HASH_W-1:0] key;
   } nht_start_type;

   typedef struct packed {
      logic idle;
   } nht_status_type;

   typedef struct packed {
      logic                     valid;
      logic                     found;
      logic [ENTRY_INDEX_W-1:0] match_index;
   } nht_result_type;

endpackage

>>> design/nht_search.sv
// hash memory and binary search sequencer for the name hash lookup block
// depends on nht_pkg and name_hash_table_lookup_top_assert.svh
`include "name_hash_table_lookup_top_assert.svh"

module nht_search #(
   parameter int unsigned TABLE_DEPTH = nht_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  nht_pkg::nht_wr_type               wr,
   input  nht_pkg::nht_start_type            start,
   input  logic [nht_pkg::COUNT_W-1:0]       entry_count,
   input  logic                              out_free,
   output nht_pkg::nht_status_type           status,
   output nht_pkg::nht_result_type           srch_res
);

   localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_CMP  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   logic [nht_pkg::HASH_W-1:0] hash_mem [TABLE_DEPTH];
   logic [nht_pkg::HASH_W-1:0] rd_data_ff;

   state_type                          state_ff, state_in;
   logic [CNT_W-1:0]                   lo_ff, lo_in;
   logic [CNT_W-1:0]                   hi_ff, hi_in;
   logic [CNT_W-1:0]                   mid_ff, mid_in;
   logic [nht_pkg::HASH_W-1:0]         key_ff, key_in;
   logic                               found_ff, found_in;
   logic [nht_pkg::ENTRY_INDEX_W-1:0]  idx_ff, idx_in;

   logic [CNT_W-1:0] n_sat;
   logic [CNT_W:0]   mid_sum;
   logic [CNT_W-1:0] mid_calc;
   logic [CNT_W-1:0] mid_plus;
   logic             rd_en;
   logic             wr_ok;

   // counts above the memory depth saturate
   assign n_sat = (32'(entry_count) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                        : CNT_W'(entry_count);

   // lo < hi here, so lo + hi - 1 never wraps
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff} - {{CNT_W{1'b0}}, 1'b1};
   assign mid_calc = mid_sum[CNT_W:1];
   assign mid_plus = mid_ff + {{(CNT_W-1){1'b0}}, 1'b1};

   assign rd_en = (state_ff == S_READ);
   assign wr_ok = wr.en && (32'(wr.entry_index) < 32'(TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         hash_mem[IDX_W'(wr.entry_index)] <= wr.entry_hash;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= hash_mem[mid_calc[IDX_W-1:0]];
      end
   end

   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      key_in   = key_ff;
      found_in = found_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start.start) begin
               key_in   = start.key;
               lo_in    = '0;
               hi_in    = n_sat;
               found_in = 1'b0;
               idx_in   = '0;
               state_in = (n_sat == '0) ? S_DONE : S_READ;
            end
         end
         S_READ: begin
            mid_in   = mid_calc;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (rd_data_ff == key_ff) begin
               found_in = 1'b1;
               idx_in   = nht_pkg::ENTRY_INDEX_W'(mid_ff);
               state_in = S_DONE;
            end else if (key_ff > rd_data_ff) begin
               lo_in    = mid_plus;
               state_in = (mid_plus < hi_ff) ? S_READ : S_DONE;
            end else begin
               hi_in    = mid_ff;
               state_in = (lo_ff < mid_ff) ? S_READ : S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      key_ff   <= key_in;
      found_ff <= found_in;
      idx_ff   <= idx_in;
   end

   assign status.idle          = (state_ff == S_IDLE);
   assign srch_res.valid       = (state_ff == S_DONE);
   assign srch_res.found       = found_ff;
   assign srch_res.match_index = idx_ff;

   `NHT_ASSERT_IMPL(a_probe_below_hi, clock, reset, state_ff == S_CMP, mid_ff < hi_ff, "probe index at or above upper bound")
   `NHT_ASSERT_IMPL(a_read_range_open, clock, reset, state_ff == S_READ, lo_ff < hi_ff, "probe issued on empty range")
   `NHT_ASSERT_IMPL(a_miss_index_zero, clock, reset, srch_res.valid && !srch_res.found, srch_res.match_index == '0, "miss with nonzero index")
   `NHT_ASSERT_NEXT(a_start_leaves_idle, clock, reset, status.idle && start.start, !status.idle, "search start ignored")
   `NHT_ASSERT_NEXT(a_done_waits, clock, reset, srch_res.valid && !out_free, srch_res.valid && $stable(found_ff) && $stable(idx_ff), "result dropped while output busy")

endmodule

>>> design/name_hash_table_lookup_top.sv
// top level of the name hash lookup block: hash fold, csr, output register
// depends on nht_pkg and nht_search
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | op, entry_index, entry_hash, name_byte, last_byte
//  rsp     | out       | rsp_valid/rsp_stall | found, match_index
//  csr     | in        | csr_valid/csr_ready | entry_count
//
// table writes and non-final name bytes are taken whenever req_stall is low and do not raise it
// a final name byte starts a search: each memory probe passes a read state and a
// compare state, up to ceil(log2(n+1)) probes over n = min(entry_count, TABLE_DEPTH)
// the search loop runs over the single read port of the hash memory
// req_stall is high while a search runs or its result waits for the rsp side
// synchronous reset clears control state; hash memory contents are not cleared

module name_hash_table_lookup_top #(
   parameter int unsigned TABLE_DEPTH = nht_pkg::TABLE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_op,
   input  logic [nht_pkg::ENTRY_INDEX_W-1:0]  req_entry_index,
   input  logic [nht_pkg::HASH_W-1:0]         req_entry_hash,
   input  logic [nht_pkg::BYTE_W-1:0]         req_name_byte,
   input  logic                               req_last_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_found,
   output logic [nht_pkg::ENTRY_INDEX_W-1:0]  rsp_match_index,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [nht_pkg::COUNT_W-1:0]        csr_entry_count
);

   logic [nht_pkg::HASH_W-1:0]        running_hash_ff, running_hash_in;
   logic [nht_pkg::COUNT_W-1:0]       entry_count_ff, entry_count_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_found_ff, rsp_found_in;
   logic [nht_pkg::ENTRY_INDEX_W-1:0] rsp_match_index_ff, rsp_match_index_in;

   logic                        req_accept;
   logic                        name_accept;
   logic [nht_pkg::HASH_W-1:0]  byte_sext;
   logic [nht_pkg::HASH_W-1:0]  folded;
   logic                        out_free;
   logic                        rsp_load;

   nht_pkg::nht_wr_type     wr;
   nht_pkg::nht_start_type  start;
   nht_pkg::nht_status_type status;
   nht_pkg::nht_result_type srch_res;

   assign req_stall   = !status.idle;
   assign req_accept  = req_valid && !req_stall;
   assign name_accept = req_accept && (req_op == nht_pkg::OP_NAME);

   // byte taken as signed char before the xor
   assign byte_sext = {{(nht_pkg::HASH_W-nht_pkg::BYTE_W){req_name_byte[nht_pkg::BYTE_W-1]}},
                       req_name_byte};
   assign folded    = (running_hash_ff ^ byte_sext) * nht_pkg::HASH_MULT;

   always_comb begin
      running_hash_in = running_hash_ff;
      if (name_accept) begin
         running_hash_in = req_last_byte ? nht_pkg::HASH_BASIS : folded;
      end
   end

   assign csr_ready      = 1'b1;
   assign entry_count_in = (csr_valid && csr_ready) ? csr_entry_count : entry_count_ff;

   assign wr.en          = req_accept && (req_op == nht_pkg::OP_WRITE);
   assign wr.entry_index = req_entry_index;
   assign wr.entry_hash  = req_entry_hash;

   assign start.start = name_accept && req_last_byte;
   assign start.key   = folded;

   nht_search #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_search (
      .clock       (clock),
      .reset       (reset),
      .wr          (wr),
      .start       (start),
      .entry_count (entry_count_ff),
      .out_free    (out_free),
      .status      (status),
      .srch_res    (srch_res)
   );

   // output register frees up in the cycle its result is taken
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = srch_res.valid && out_free;

   assign rsp_valid_in       = rsp_load || (rsp_valid_ff && rsp_stall);
   assign rsp_found_in       = rsp_load ? srch_res.found : rsp_found_ff;
   assign rsp_match_index_in = rsp_load ? srch_res.match_index : rsp_match_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         running_hash_ff <= nht_pkg::HASH_BASIS;
         entry_count_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         running_hash_ff <= running_hash_in;
         entry_count_ff  <= entry_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff       <= rsp_found_in;
      rsp_match_index_ff <= rsp_match_index_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_index = rsp_match_index_ff;

endmodule

>>> test/name_hash_table_lookup_top_test.sv
// self-checking testbench for name_hash_table_lookup_top: table writes, name hashing and search
// depends on nht_pkg and the name_hash_table_lookup_top rtl; the lookup predictor is kept here
module name_hash_table_lookup_top_test;

   localparam int DICT_SIZE          = 48;
   localparam int MAX_NAME_LEN       = 8;
   localparam int SETTLE_CYCLES      = 40;
   localparam int LONG_HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT        = 400000;
   localparam int PRELOAD_ENTRIES    = 32;
   localparam int PRESSURE_NAMES     = 6;
   localparam int RANDOM_PHASE_ITEMS = 12;

   typedef struct packed {
      logic                              found;
      logic [nht_pkg::ENTRY_INDEX_W-1:0] match_index;
   } lookup_result_type;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic                              req_op;
   logic [nht_pkg::ENTRY_INDEX_W-1:0] req_entry_index;
   logic [nht_pkg::HASH_W-1:0]        req_entry_hash;
   logic [nht_pkg::BYTE_W-1:0]        req_name_byte;
   logic                              req_last_byte;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic                              rsp_found;
   logic [nht_pkg::ENTRY_INDEX_W-1:0] rsp_match_index;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [nht_pkg::COUNT_W-1:0]       csr_entry_count;

   // predictor state
   logic [nht_pkg::HASH_W-1:0]  model_table [nht_pkg::TABLE_DEPTH_DEF];
   bit                          written [nht_pkg::TABLE_DEPTH_DEF];
   logic [nht_pkg::HASH_W-1:0]  model_hash;
   logic [nht_pkg::COUNT_W-1:0] model_count;
   lookup_result_type           lookup_q [$];

   // stimulus knowledge: sorted table image and a dictionary of names in it
   logic [nht_pkg::HASH_W-1:0] sorted_image [nht_pkg::TABLE_DEPTH_DEF];
   logic [nht_pkg::BYTE_W-1:0] dict_bytes [DICT_SIZE][MAX_NAME_LEN];
   int                         dict_len [DICT_SIZE];
   logic [nht_pkg::HASH_W-1:0] dict_hash [DICT_SIZE];
   int                         min_name;
   int                         max_name;

   bit pace_idle     = 1'b1;
   bit mix_writes    = 1'b0;
   bit long_hold_req = 1'b0;
   int mismatch_count = 0;
   int items_sent     = 0;
   int cycle_count    = 0;

   name_hash_table_lookup_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_entry_index (req_entry_index),
      .req_entry_hash  (req_entry_hash),
      .req_name_byte   (req_name_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_match_index (rsp_match_index),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_entry_count (csr_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("name_hash_table_lookup_top test failed");
         $finish;
      end
   end

   // byte is sign-extended before the xor
   function automatic logic [nht_pkg::HASH_W-1:0] fold_name_byte(
         input logic [nht_pkg::HASH_W-1:0] h,
         input logic [nht_pkg::BYTE_W-1:0] b);
      return (h ^ {{(nht_pkg::HASH_W-nht_pkg::BYTE_W){b[nht_pkg::BYTE_W-1]}}, b})
             * nht_pkg::HASH_MULT;
   endfunction

   // entries in use, counts above the depth saturate
   function automatic int unsigned search_limit();
      if (model_count > nht_pkg::TABLE_DEPTH_DEF)
         return nht_pkg::TABLE_DEPTH_DEF;
      return model_count;
   endfunction

   function automatic void predict_request(input logic op,
                                           input logic [nht_pkg::ENTRY_INDEX_W-1:0] idx,
                                           input logic [nht_pkg::HASH_W-1:0] eh,
                                           input logic [nht_pkg::BYTE_W-1:0] nb,
                                           input logic last);
      int unsigned       lo;
      int unsigned       hi;
      int unsigned       mid;
      lookup_result_type r;
      if (op == nht_pkg::OP_WRITE) begin
         model_table[idx] = eh;
         written[idx]     = 1'b1;
         return;
      end
      model_hash = fold_name_byte(model_hash, nb);
      if (!last)
         return;
      r  = '0;
      lo = 0;
      hi = search_limit();
      while (lo < hi) begin
         mid = (lo + hi - 1) / 2;
         if (model_table[mid] == model_hash) begin
            r.found       = 1'b1;
            r.match_index = nht_pkg::ENTRY_INDEX_W'(mid);
            break;
         end else if (model_hash > model_table[mid]) begin
            lo = mid + 1;
         end else begin
            hi = mid;
         end
      end
      lookup_q.push_back(r);
      model_hash = nht_pkg::HASH_BASIS;
   endfunction

   task automatic send_request(input logic op,
                               input logic [nht_pkg::ENTRY_INDEX_W-1:0] idx,
                               input logic [nht_pkg::HASH_W-1:0] eh,
                               input logic [nht_pkg::BYTE_W-1:0] nb,
                               input logic last);
      int unsigned gap;
      gap = pace_idle ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_entry_index <= idx;
      req_entry_hash  <= eh;
      req_name_byte   <= nb;
      req_last_byte   <= last;
      do begin
         @(posedge clock);
      end while (req_stall !== 1'b0);
      predict_request(op, idx, eh, nb, last);
      items_sent++;
   endtask

   task automatic send_table_write(input logic [nht_pkg::ENTRY_INDEX_W-1:0] idx,
                                   input logic [nht_pkg::HASH_W-1:0] value);
      send_request(nht_pkg::OP_WRITE, idx, value, nht_pkg::BYTE_W'($urandom), 1'($urandom));
   endtask

   // walk the coming search and write every probed entry that is still empty
   task automatic fill_probe_path(input logic [nht_pkg::HASH_W-1:0] key);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = search_limit();
      while (lo < hi) begin
         mid = (lo + hi - 1) / 2;
         if (!written[mid])
            send_table_write(nht_pkg::ENTRY_INDEX_W'(mid), sorted_image[mid]);
         if (model_table[mid] == key)
            break;
         else if (key > model_table[mid])
            lo = mid + 1;
         else
            hi = mid;
      end
   endtask

   // rewrites the sorted value mostly, sometimes breaks the order
   task automatic send_random_write();
      logic [nht_pkg::ENTRY_INDEX_W-1:0] idx;
      idx = nht_pkg::ENTRY_INDEX_W'($urandom);
      if ($urandom_range(0, 2) == 0)
         send_table_write(idx, $urandom);
      else
         send_table_write(idx, sorted_image[idx]);
   endtask

   // k selects a dictionary name, a negative k a random one
   task automatic send_name(input int k);
      int                         len;
      logic [nht_pkg::BYTE_W-1:0] b;
      len = (k >= 0) ? dict_len[k] : $urandom_range(1, MAX_NAME_LEN);
      for (int i = 0; i < len; i++) begin
         if (k >= 0)
            b = dict_bytes[k][i];
         else
            b = nht_pkg::BYTE_W'($urandom);
         if (mix_writes && $urandom_range(0, 9) == 0)
            send_random_write();
         if (i == len - 1)
            fill_probe_path(fold_name_byte(model_hash, b));
         send_request(nht_pkg::OP_NAME, nht_pkg::ENTRY_INDEX_W'($urandom), $urandom, b,
                      i == len - 1);
      end
   endtask

   task automatic send_short_name(input logic [nht_pkg::BYTE_W-1:0] b);
      fill_probe_path(fold_name_byte(model_hash, b));
      send_request(nht_pkg::OP_NAME, nht_pkg::ENTRY_INDEX_W'($urandom), $urandom, b, 1'b1);
   endtask

   // drop valid, wait for every result, then let trailing writes finish
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (lookup_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_entry_count(input logic [nht_pkg::COUNT_W-1:0] value);
      wait_drained();
      csr_valid       <= 1'b1;
      csr_entry_count <= value;
      do begin
         @(posedge clock);
      end while (csr_ready !== 1'b1);
      csr_valid   <= 1'b0;
      model_count = value;
   endtask

   // receiver: random stall after each result, or one long hold on request
   initial begin : rsp_side
      int unsigned stall_left;
      stall_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            stall_left = 0;
         end else if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            stall_left = pace_idle ? $urandom_range(0, 3) : 0;
         end else if (stall_left != 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   always @(posedge clock) begin : check_results
      lookup_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (lookup_q.size() == 0) begin
            $error("result with no lookup pending: found %0b match_index %0d",
                   rsp_found, rsp_match_index);
            mismatch_count++;
         end else begin
            want = lookup_q.pop_front();
            if (rsp_found !== want.found) begin
               $error("found: expected %0b, actual %0b", want.found, rsp_found);
               mismatch_count++;
            end
            if (rsp_match_index !== want.match_index) begin
               $error("match_index: expected %0d, actual %0d",
                      want.match_index, rsp_match_index);
               mismatch_count++;
            end
         end
      end
   end

   // no entries in use: every search misses, byte sign extension and zero bytes
   task automatic test_empty_table();
      write_entry_count('0);
      send_table_write('0, '0);
      send_table_write('1, '1);
      send_short_name(8'h00);
      send_short_name(8'h7f);
      send_short_name(8'h80);
      send_short_name(8'hff);
      send_request(nht_pkg::OP_NAME, '0, '0, 8'h41, 1'b0);
      send_request(nht_pkg::OP_NAME, '1, '1, 8'h00, 1'b0);
      send_request(nht_pkg::OP_NAME, '0, '1, 8'hc3, 1'b1);
   endtask

   // dictionary hashes bound the table image, so the smallest and largest sit at the ends;
   // only a short prefix is written here, later searches write the entries they probe
   task automatic test_load_table();
      logic [nht_pkg::HASH_W-1:0] fill_q [$];
      logic [nht_pkg::HASH_W-1:0] h;
      logic [nht_pkg::HASH_W-1:0] lo_h;
      logic [nht_pkg::HASH_W-1:0] hi_h;
      lo_h = '1;
      hi_h = '0;
      for (int k = 0; k < DICT_SIZE; k++) begin
         dict_len[k] = $urandom_range(1, MAX_NAME_LEN);
         h = nht_pkg::HASH_BASIS;
         for (int i = 0; i < dict_len[k]; i++) begin
            dict_bytes[k][i] = nht_pkg::BYTE_W'($urandom);
            h = fold_name_byte(h, dict_bytes[k][i]);
         end
         dict_hash[k] = h;
         fill_q.push_back(h);
         if (h <= lo_h) begin
            lo_h     = h;
            min_name = k;
         end
         if (h >= hi_h) begin
            hi_h     = h;
            max_name = k;
         end
      end
      while (fill_q.size() < nht_pkg::TABLE_DEPTH_DEF)
         fill_q.push_back($urandom_range(hi_h - 1, lo_h + 1));
      fill_q.sort();
      for (int i = 0; i < nht_pkg::TABLE_DEPTH_DEF; i++)
         sorted_image[i] = fill_q[i];
      for (int i = 0; i < PRELOAD_ENTRIES; i++)
         send_table_write(nht_pkg::ENTRY_INDEX_W'(i), sorted_image[i]);
      write_entry_count(nht_pkg::COUNT_W'(PRELOAD_ENTRIES));
      send_name(min_name);
      send_name(max_name);
      send_name(-1);
   endtask

   // one entry, two entries, full table and a count above the depth
   task automatic test_count_extremes();
      logic [nht_pkg::COUNT_W-1:0] counts [4];
      counts = '{13'd1, 13'd2, 13'd4096, 13'd8191};
      foreach (counts[c]) begin
         write_entry_count(counts[c]);
         send_name(min_name);
         send_name(max_name);
         send_name($urandom_range(0, DICT_SIZE - 1));
         send_name(-1);
      end
   endtask

   // out-of-order entries: the probe sequence decides what is hit
   task automatic test_unsorted_entries();
      int k;
      k = $urandom_range(0, DICT_SIZE - 1);
      write_entry_count(13'd5);
      send_table_write(12'd0, dict_hash[max_name]);
      send_table_write(12'd1, $urandom);
      send_table_write(12'd2, dict_hash[min_name]);
      send_table_write(12'd3, $urandom);
      send_table_write(12'd4, dict_hash[k]);
      send_name(max_name);
      send_name(min_name);
      send_name(k);
      send_name(-1);
      for (int i = 0; i < 5; i++)
         send_table_write(nht_pkg::ENTRY_INDEX_W'(i), sorted_image[i]);
   endtask

   // receiver holds off while names keep coming, so the request side stalls
   task automatic test_back_pressure();
      write_entry_count(13'd4096);
      long_hold_req = 1'b1;
      for (int i = 0; i < PRESSURE_NAMES; i++)
         send_name($urandom_range(0, DICT_SIZE - 1));
      wait_drained();
   endtask

   // one name at a time, no idling on either side
   task automatic test_paced_names();
      write_entry_count(13'($urandom_range(1, 4095)));
      pace_idle = 1'b0;
      for (int i = 0; i < 8; i++) begin
         send_name((i % 3 == 2) ? -1 : $urandom_range(0, DICT_SIZE - 1));
         wait_drained();
      end
      pace_idle = 1'b1;
   endtask

   task automatic test_random_mix();
      logic [nht_pkg::COUNT_W-1:0] counts [8];
      int                          first_item;
      int unsigned                 pick;
      counts = '{13'd4096, 13'($urandom_range(3, 4095)), 13'd8191, 13'd64,
                 13'($urandom_range(1, 4095)), 13'd4096, 13'd1000,
                 13'($urandom_range(4097, 8191))};
      mix_writes = 1'b1;
      foreach (counts[p]) begin
         write_entry_count(counts[p]);
         pace_idle  = (p % 3 != 2);
         first_item = items_sent;
         while (items_sent - first_item < RANDOM_PHASE_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
               send_name($urandom_range(0, DICT_SIZE - 1));
            else if (pick < 9)
               send_name(-1);
            else
               send_random_write();
         end
      end
      mix_writes = 1'b0;
      pace_idle  = 1'b1;
   endtask

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_op          <= nht_pkg::OP_WRITE;
      req_entry_index <= '0;
      req_entry_hash  <= '0;
      req_name_byte   <= '0;
      req_last_byte   <= 1'b0;
      csr_valid       <= 1'b0;
      csr_entry_count <= '0;
      model_hash  = nht_pkg::HASH_BASIS;
      model_count = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_load_table();
      test_count_extremes();
      test_unsorted_entries();
      test_back_pressure();
      test_paced_names();
      test_random_mix();

      wait_drained();
      if (mismatch_count == 0)
         $display("name_hash_table_lookup_top test passed");
      else
         $display("name_hash_table_lookup_top test failed");
      $finish;
   end

endmodule
